@@ sv/eig_pkg.sv @@
// ----------------------------------------------------------------------------
// eig_pkg
// Shared constant for the 2x2 eigen decomposition datapath.
// ----------------------------------------------------------------------------
package eig_pkg;

   // vector magnitudes are brought below 2^NORM_LIMIT before the length root
   localparam int unsigned NORM_LIMIT = 31;

endpackage

@@ sv/eigen_decomposition_2x2.sv @@
// ----------------------------------------------------------------------------
// eigen_decomposition_2x2
// Closed-form eigenvalues and unit eigenvectors of a real 2x2 matrix.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   start / busy     req_entry_a .. req_entry_d
//  response  rsp_valid        rsp_lambda_*, rsp_vec_*, rsp_*_flag
//
//  A request is taken in every cycle that start is high and busy is low;
//  busy is high during reset and in the first cycle after it.
//  The discriminant root, the vector length root and the divider each retire
//  one bit per stage. rsp_valid pulses one cycle per request.
//  Reset clears the valid bits and raises busy; the pipeline never stalls.
// ----------------------------------------------------------------------------
module eigen_decomposition_2x2 import eig_pkg::*; #(
   parameter int DATA_WIDTH = 24,
   parameter int FRAC_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [DATA_WIDTH-1:0]   req_entry_a,
   input  logic [DATA_WIDTH-1:0]   req_entry_b,
   input  logic [DATA_WIDTH-1:0]   req_entry_c,
   input  logic [DATA_WIDTH-1:0]   req_entry_d,
   output logic                    rsp_valid,
   output logic [DATA_WIDTH+2:0]   rsp_lambda_one,
   output logic [DATA_WIDTH+2:0]   rsp_lambda_two,
   output logic [FRAC_BITS+1:0]    rsp_vec_one_x,
   output logic [FRAC_BITS+1:0]    rsp_vec_one_y,
   output logic [FRAC_BITS+1:0]    rsp_vec_two_x,
   output logic [FRAC_BITS+1:0]    rsp_vec_two_y,
   output logic                    rsp_complex_flag,
   output logic [1:0]              rsp_degenerate_flag
);

   localparam int DW  = DATA_WIDTH;
   localparam int LW  = DW + 3;
   localparam int VW  = FRAC_BITS + 2;
   localparam int MW  = DW + 1;
   localparam int PW  = (MW > NORM_LIMIT) ? NORM_LIMIT : MW;
   localparam int KX  = MW - PW;
   localparam int RN  = 2 * DW + 2;
   localparam int RM  = DW + 1;
   localparam int SN  = 2 * PW + 2;
   localparam int SM  = PW + 1;
   localparam int QW  = FRAC_BITS + 1;
   localparam int S1W = 2 * DW + (DW + 1) + 1;
   localparam int S2A = 2 * PW + 3 + 2 * LW + 1;
   localparam int S2B = 2 * PW + 3;
   localparam int D1W = 3 + 2 * LW + 1;
   localparam int D2W = 3;

   // shift both magnitudes right together until their or is below the limit
   function automatic logic [PW-1:0] norm_mag(input logic [MW-1:0] x,
                                              input logic [MW-1:0] orv);
      logic [PW-1:0] res;
      res = x[PW-1:0];
      for (int i = 1; i <= KX; i++) begin
         if ((orv >> (PW - 1 + i)) != '0) begin
            res = PW'(x >> i);
         end
      end
      return res;
   endfunction

   logic busy_ff;

   // stage 1: capture
   logic          v1_ff;
   logic [DW-1:0] a1_ff, b1_ff, c1_ff, d1_ff;

   // stage 2: difference, product bc, trace
   logic            v2_ff;
   logic [DW-1:0]   u2_ff, u2_in;
   logic [2*DW-1:0] bc2_ff;
   logic [DW:0]     tr2_ff, tr2_in;
   logic [DW-1:0]   a2_ff, b2_ff;

   // stage 3: square of difference
   logic            v3_ff;
   logic [2*DW-1:0] usq3_ff, bc3_ff;
   logic [DW:0]     tr3_ff;
   logic [DW-1:0]   a3_ff, b3_ff;

   // stage 4: discriminant
   logic          v4_ff;
   logic [RN-1:0] rad4_ff, rad4_in;
   logic          cplx4_ff, cplx4_in;
   logic [DW:0]   tr4_ff;
   logic [DW-1:0] a4_ff, b4_ff;

   logic           r1_valid;
   logic [RM-1:0]  r1_root;
   logic [S1W-1:0] r1_side;
   logic [DW-1:0]  r1_a, r1_b;
   logic [DW:0]    r1_tr;
   logic           r1_cplx;

   // stage 5: eigenvalues
   logic          v5_ff;
   logic [LW-1:0] lam5_ff [2];
   logic [LW-1:0] lam5_in [2];
   logic [DW-1:0] a5_ff, b5_ff;
   logic          cplx5_ff;

   // stage 6: vector magnitudes
   logic          v6_ff;
   logic [MW-1:0] mx6_ff, mx6_in;
   logic [MW-1:0] my6_ff [2];
   logic [MW-1:0] my6_in [2];
   logic [1:0]    mpos6_ff, mpos6_in;
   logic          bneg6_ff;
   logic [LW-1:0] lam6_ff [2];
   logic          cplx6_ff;

   // stage 7: normalized magnitudes
   logic          v7_ff;
   logic [PW-1:0] p7_ff [2];
   logic [PW-1:0] p7_in [2];
   logic [PW-1:0] q7_ff [2];
   logic [PW-1:0] q7_in [2];
   logic [1:0]    degen7_ff, degen7_in;
   logic [1:0]    mpos7_ff;
   logic          bneg7_ff;
   logic [LW-1:0] lam7_ff [2];
   logic          cplx7_ff;

   // stage 8: squares
   logic            v8_ff;
   logic [2*PW-1:0] pp8_ff [2];
   logic [2*PW-1:0] qq8_ff [2];
   logic [PW-1:0]   p8_ff [2];
   logic [PW-1:0]   q8_ff [2];
   logic [1:0]      degen8_ff, mpos8_ff;
   logic            bneg8_ff;
   logic [LW-1:0]   lam8_ff [2];
   logic            cplx8_ff;

   // stage 9: sum of squares
   logic          v9_ff;
   logic [SN-1:0] ss9_ff [2];
   logic [PW-1:0] p9_ff [2];
   logic [PW-1:0] q9_ff [2];
   logic [1:0]    degen9_ff, mpos9_ff;
   logic          bneg9_ff;
   logic [LW-1:0] lam9_ff [2];
   logic          cplx9_ff;

   logic           l0_valid, l1_valid;
   logic [SM-1:0]  l0_len, l1_len, l0_den, l1_den;
   logic [S2A-1:0] l0_side;
   logic [S2B-1:0] l1_side;
   logic [PW-1:0]  l0_p, l0_q, l1_p, l1_q;
   logic [D1W-1:0] l0_dside;
   logic [D2W-1:0] l1_dside;

   logic           q0_valid, q1_valid;
   logic [QW-1:0]  q0_x, q0_y, q1_x, q1_y;
   logic [D1W-1:0] q0_side;
   logic [D2W-1:0] q1_side;
   logic           o_bneg, o_mpos0, o_degen0, o_mpos1, o_degen1, o_cplx, o_bneg1;
   logic [LW-1:0]  o_lam1, o_lam2;

   logic          rsp_valid_ff;
   logic [LW-1:0] lam1_ff, lam2_ff;
   logic [VW-1:0] v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic [VW-1:0] v1x_in, v1y_in, v2x_in, v2y_in;
   logic          cplx_ff;
   logic [1:0]    degen_ff;

   // ---------------- front end: discriminant ----------------

   always_comb begin
      logic [DW:0] diff;
      logic [DW:0] ndiff;
      diff   = {a1_ff[DW-1], a1_ff} - {d1_ff[DW-1], d1_ff};
      ndiff  = -diff;
      u2_in  = diff[DW] ? ndiff[DW-1:0] : diff[DW-1:0];
      tr2_in = {a1_ff[DW-1], a1_ff} + {d1_ff[DW-1], d1_ff};
   end

   always_comb begin
      logic [RN-1:0] disc;
      disc     = {2'b00, usq3_ff} + {bc3_ff, 2'b00};
      cplx4_in = disc[RN-1];
      rad4_in  = cplx4_in ? '0 : disc;
   end

   eig_sqrt #(
      .RAD_W  (RN),
      .SIDE_W (S1W)
   ) u_disc_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_rad    (rad4_ff),
      .in_side   ({a4_ff, b4_ff, tr4_ff, cplx4_ff}),
      .out_valid (r1_valid),
      .out_root  (r1_root),
      .out_side  (r1_side)
   );

   assign {r1_a, r1_b, r1_tr, r1_cplx} = r1_side;

   // ---------------- eigenvalues and vector setup ----------------

   always_comb begin
      logic [LW-1:0] tr_ext;
      logic [LW-1:0] root_ext;
      logic [LW-1:0] s_sum;
      logic [LW-1:0] s_dif;
      tr_ext     = {{(LW-DW-1){r1_tr[DW]}}, r1_tr};
      root_ext   = {{(LW-RM){1'b0}}, r1_root};
      s_sum      = tr_ext + root_ext;
      s_dif      = tr_ext - root_ext;
      // floor halving
      lam5_in[0] = {s_sum[LW-1], s_sum[LW-1:1]};
      lam5_in[1] = {s_dif[LW-1], s_dif[LW-1:1]};
   end

   always_comb begin
      logic [LW-1:0] a_ext;
      logic [LW-1:0] m;
      logic [LW-1:0] mneg;
      logic [MW-1:0] b_ext;
      logic [MW-1:0] bneg;
      a_ext  = {{(LW-DW){a5_ff[DW-1]}}, a5_ff};
      b_ext  = {b5_ff[DW-1], b5_ff};
      bneg   = -b_ext;
      mx6_in = b5_ff[DW-1] ? bneg : b_ext;
      for (int l = 0; l < 2; l++) begin
         m           = a_ext - lam5_ff[l];
         mneg        = -m;
         mpos6_in[l] = !m[LW-1] && (m != '0);
         my6_in[l]   = m[LW-1] ? mneg[MW-1:0] : m[MW-1:0];
      end
   end

   always_comb begin
      logic [MW-1:0] orv;
      for (int l = 0; l < 2; l++) begin
         orv          = mx6_ff | my6_ff[l];
         degen7_in[l] = (orv == '0);
         p7_in[l]     = norm_mag(mx6_ff, orv);
         q7_in[l]     = norm_mag(my6_ff[l], orv);
      end
   end

   // ---------------- pipeline registers ----------------

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         v9_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         v1_ff        <= start && !busy_ff;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= r1_valid;
         v6_ff        <= v5_ff;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         v9_ff        <= v8_ff;
         rsp_valid_ff <= q0_valid && q1_valid;
      end
   end

   always_ff @(posedge clock) begin
      a1_ff <= req_entry_a;
      b1_ff <= req_entry_b;
      c1_ff <= req_entry_c;
      d1_ff <= req_entry_d;

      u2_ff  <= u2_in;
      bc2_ff <= (2*DW)'($signed(b1_ff) * $signed(c1_ff));
      tr2_ff <= tr2_in;
      a2_ff  <= a1_ff;
      b2_ff  <= b1_ff;

      usq3_ff <= (2*DW)'(u2_ff * u2_ff);
      bc3_ff  <= bc2_ff;
      tr3_ff  <= tr2_ff;
      a3_ff   <= a2_ff;
      b3_ff   <= b2_ff;

      rad4_ff  <= rad4_in;
      cplx4_ff <= cplx4_in;
      tr4_ff   <= tr3_ff;
      a4_ff    <= a3_ff;
      b4_ff    <= b3_ff;

      a5_ff    <= r1_a;
      b5_ff    <= r1_b;
      cplx5_ff <= r1_cplx;

      mx6_ff   <= mx6_in;
      mpos6_ff <= mpos6_in;
      bneg6_ff <= b5_ff[DW-1];
      cplx6_ff <= cplx5_ff;

      degen7_ff <= degen7_in;
      mpos7_ff  <= mpos6_ff;
      bneg7_ff  <= bneg6_ff;
      cplx7_ff  <= cplx6_ff;

      degen8_ff <= degen7_ff;
      mpos8_ff  <= mpos7_ff;
      bneg8_ff  <= bneg7_ff;
      cplx8_ff  <= cplx7_ff;

      degen9_ff <= degen8_ff;
      mpos9_ff  <= mpos8_ff;
      bneg9_ff  <= bneg8_ff;
      cplx9_ff  <= cplx8_ff;

      for (int l = 0; l < 2; l++) begin
         lam5_ff[l] <= lam5_in[l];
         lam6_ff[l] <= lam5_ff[l];
         my6_ff[l]  <= my6_in[l];
         p7_ff[l]   <= p7_in[l];
         q7_ff[l]   <= q7_in[l];
         lam7_ff[l] <= lam6_ff[l];
         pp8_ff[l]  <= (2*PW)'(p7_ff[l] * p7_ff[l]);
         qq8_ff[l]  <= (2*PW)'(q7_ff[l] * q7_ff[l]);
         p8_ff[l]   <= p7_ff[l];
         q8_ff[l]   <= q7_ff[l];
         lam8_ff[l] <= lam7_ff[l];
         ss9_ff[l]  <= {2'b00, pp8_ff[l]} + {2'b00, qq8_ff[l]};
         p9_ff[l]   <= p8_ff[l];
         q9_ff[l]   <= q8_ff[l];
         lam9_ff[l] <= lam8_ff[l];
      end
   end

   // ---------------- vector lengths ----------------

   eig_sqrt #(
      .RAD_W  (SN),
      .SIDE_W (S2A)
   ) u_len_root_one (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v9_ff),
      .in_rad    (ss9_ff[0]),
      .in_side   ({p9_ff[0], q9_ff[0], bneg9_ff, mpos9_ff[0], degen9_ff[0],
                   lam9_ff[0], lam9_ff[1], cplx9_ff}),
      .out_valid (l0_valid),
      .out_root  (l0_len),
      .out_side  (l0_side)
   );

   eig_sqrt #(
      .RAD_W  (SN),
      .SIDE_W (S2B)
   ) u_len_root_two (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v9_ff),
      .in_rad    (ss9_ff[1]),
      .in_side   ({p9_ff[1], q9_ff[1], bneg9_ff, mpos9_ff[1], degen9_ff[1]}),
      .out_valid (l1_valid),
      .out_root  (l1_len),
      .out_side  (l1_side)
   );

   assign {l0_p, l0_q}   = l0_side[S2A-1 -: 2*PW];
   assign l0_dside       = l0_side[D1W-1:0];
   assign {l1_p, l1_q}   = l1_side[S2B-1 -: 2*PW];
   assign l1_dside       = l1_side[D2W-1:0];
   // a zero length only comes with a zero vector, divide by one then
   assign l0_den = (l0_len == '0) ? SM'(1) : l0_len;
   assign l1_den = (l1_len == '0) ? SM'(1) : l1_len;

   // ---------------- unit vector components ----------------

   eig_div #(
      .DEN_W  (SM),
      .NUM_W  (PW),
      .QUO_W  (QW),
      .SIDE_W (D1W)
   ) u_div_one (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l0_valid),
      .in_den    (l0_den),
      .in_num_x  (l0_p),
      .in_num_y  (l0_q),
      .in_side   (l0_dside),
      .out_valid (q0_valid),
      .out_quo_x (q0_x),
      .out_quo_y (q0_y),
      .out_side  (q0_side)
   );

   eig_div #(
      .DEN_W  (SM),
      .NUM_W  (PW),
      .QUO_W  (QW),
      .SIDE_W (D2W)
   ) u_div_two (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (l1_valid),
      .in_den    (l1_den),
      .in_num_x  (l1_p),
      .in_num_y  (l1_q),
      .in_side   (l1_dside),
      .out_valid (q1_valid),
      .out_quo_x (q1_x),
      .out_quo_y (q1_y),
      .out_side  (q1_side)
   );

   assign {o_bneg, o_mpos0, o_degen0, o_lam1, o_lam2, o_cplx} = q0_side;
   assign {o_bneg1, o_mpos1, o_degen1} = q1_side;

   always_comb begin
      logic [VW-1:0] x0, y0, x1, y1;
      x0 = VW'(q0_x);
      y0 = VW'(q0_y);
      x1 = VW'(q1_x);
      y1 = VW'(q1_y);
      v1x_in = o_degen0 ? '0 : (o_bneg  ? -x0 : x0);
      v1y_in = o_degen0 ? '0 : (o_mpos0 ? -y0 : y0);
      v2x_in = o_degen1 ? '0 : (o_bneg1 ? -x1 : x1);
      v2y_in = o_degen1 ? '0 : (o_mpos1 ? -y1 : y1);
   end

   always_ff @(posedge clock) begin
      lam1_ff  <= o_lam1;
      lam2_ff  <= o_lam2;
      v1x_ff   <= v1x_in;
      v1y_ff   <= v1y_in;
      v2x_ff   <= v2x_in;
      v2y_ff   <= v2y_in;
      cplx_ff  <= o_cplx;
      degen_ff <= {o_degen1, o_degen0};
   end

   assign busy                = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_lambda_one      = lam1_ff;
   assign rsp_lambda_two      = lam2_ff;
   assign rsp_vec_one_x       = v1x_ff;
   assign rsp_vec_one_y       = v1y_ff;
   assign rsp_vec_two_x       = v2x_ff;
   assign rsp_vec_two_y       = v2y_ff;
   assign rsp_complex_flag    = cplx_ff;
   assign rsp_degenerate_flag = degen_ff;

endmodule

@@ sv/eig_sqrt.sv @@
// ----------------------------------------------------------------------------
// eig_sqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module eig_sqrt #(
   parameter int RAD_W  = 50,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [RAD_W-1:0]     in_rad,
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output logic [RAD_W/2-1:0]   out_root,
   output logic [SIDE_W-1:0]    out_side
);

   localparam int RW = RAD_W / 2;

   logic [RW-1:0]     v_ff;
   logic [RW+1:0]     x_ff    [RW];
   logic [RW+1:0]     x_in    [RW];
   logic [RW-1:0]     r_ff    [RW];
   logic [RW-1:0]     r_in    [RW];
   logic [RAD_W-1:0]  n_ff    [RW];
   logic [SIDE_W-1:0] side_ff [RW];

   always_comb begin
      logic [RW+1:0]    xp;
      logic [RW-1:0]    rp;
      logic [RAD_W-1:0] np;
      logic [RW+1:0]    x_cat;
      logic [RW+1:0]    trial;
      logic             fit;
      for (int g = 0; g < RW; g++) begin
         if (g == 0) begin
            xp = '0;
            rp = '0;
            np = in_rad;
         end else begin
            xp = x_ff[g-1];
            rp = r_ff[g-1];
            np = n_ff[g-1];
         end
         // bring in the next radicand bit pair, try (4r + 1)
         x_cat = {xp[RW-1:0], np[2*(RW-1-g)+1 -: 2]};
         trial = {rp, 2'b01};
         fit   = (x_cat >= trial);
         x_in[g] = fit ? (x_cat - trial) : x_cat;
         r_in[g] = {rp[RW-2:0], fit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[RW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < RW; g++) begin
         x_ff[g] <= x_in[g];
         r_ff[g] <= r_in[g];
         n_ff[g] <= (g == 0) ? in_rad : n_ff[g-1];
         side_ff[g] <= (g == 0) ? in_side : side_ff[g-1];
      end
   end

   assign out_valid = v_ff[RW-1];
   assign out_root  = r_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

@@ sv/eig_div.sv @@
// ----------------------------------------------------------------------------
// eig_div
// Pipelined restoring divider, two numerators over one shared divisor,
// one quotient bit per register stage. Numerators must not exceed the divisor.
// ----------------------------------------------------------------------------
module eig_div #(
   parameter int DEN_W  = 26,
   parameter int NUM_W  = 25,
   parameter int QUO_W  = 17,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [DEN_W-1:0]   in_den,
   input  logic [NUM_W-1:0]   in_num_x,
   input  logic [NUM_W-1:0]   in_num_y,
   input  logic [SIDE_W-1:0]  in_side,
   output logic               out_valid,
   output logic [QUO_W-1:0]   out_quo_x,
   output logic [QUO_W-1:0]   out_quo_y,
   output logic [SIDE_W-1:0]  out_side
);

   logic [QUO_W-1:0]  v_ff;
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [DEN_W-1:0]  rx_ff   [QUO_W];
   logic [DEN_W-1:0]  rx_in   [QUO_W];
   logic [DEN_W-1:0]  ry_ff   [QUO_W];
   logic [DEN_W-1:0]  ry_in   [QUO_W];
   logic [QUO_W-1:0]  qx_ff   [QUO_W];
   logic [QUO_W-1:0]  qx_in   [QUO_W];
   logic [QUO_W-1:0]  qy_ff   [QUO_W];
   logic [QUO_W-1:0]  qy_in   [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   always_comb begin
      logic [DEN_W-1:0] dp;
      logic [DEN_W:0]   catx;
      logic [DEN_W:0]   caty;
      logic [DEN_W:0]   difx;
      logic [DEN_W:0]   dify;
      logic             fx;
      logic             fy;
      for (int g = 0; g < QUO_W; g++) begin
         if (g == 0) begin
            dp   = in_den;
            catx = (DEN_W+1)'(in_num_x);
            caty = (DEN_W+1)'(in_num_y);
         end else begin
            dp   = den_ff[g-1];
            catx = {rx_ff[g-1], 1'b0};
            caty = {ry_ff[g-1], 1'b0};
         end
         difx = catx - {1'b0, dp};
         dify = caty - {1'b0, dp};
         fx   = (catx >= {1'b0, dp});
         fy   = (caty >= {1'b0, dp});
         rx_in[g] = fx ? difx[DEN_W-1:0] : catx[DEN_W-1:0];
         ry_in[g] = fy ? dify[DEN_W-1:0] : caty[DEN_W-1:0];
         if (g == 0) begin
            qx_in[g] = QUO_W'(fx);
            qy_in[g] = QUO_W'(fy);
         end else begin
            qx_in[g] = {qx_ff[g-1][QUO_W-2:0], fx};
            qy_in[g] = {qy_ff[g-1][QUO_W-2:0], fy};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[QUO_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < QUO_W; g++) begin
         den_ff[g]  <= (g == 0) ? in_den : den_ff[g-1];
         side_ff[g] <= (g == 0) ? in_side : side_ff[g-1];
         rx_ff[g]   <= rx_in[g];
         ry_ff[g]   <= ry_in[g];
         qx_ff[g]   <= qx_in[g];
         qy_ff[g]   <= qy_in[g];
      end
   end

   assign out_valid = v_ff[QUO_W-1];
   assign out_quo_x = qx_ff[QUO_W-1];
   assign out_quo_y = qy_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule
